/* hdl/lw_pkg.sv */
package lw_pkg;

  localparam int MAX_PASSES_DEF = 10;
  localparam int FRAC_BITS_DEF  = 32;

  localparam logic [63:0]        LIM_U   = 64'h2000_0000_0000_0000;
  localparam logic signed [63:0] LIM     = 64'sh2000_0000_0000_0000;
  localparam logic [63:0]        LN2_Q56 = 64'h00B1_7217_F7D1_CF7A;
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_000F_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = -64'sh0000_0010_0000_0000;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } lw_op_t;

  // request to the shared multiply / divide unit
  typedef struct packed {
    lw_op_t      op;
    logic        sgn;
    logic        rnd;
    logic [5:0]  sh;
    logic [63:0] a;
    logic [63:0] b;
  } lw_req_t;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic signed [63:0] sat_mag(input logic [63:0] m, input logic neg);
    logic [63:0] v;
    v = (m > LIM_U) ? LIM_U : m;
    return neg ? $signed(64'd0 - v) : $signed(v);
  endfunction

  function automatic logic signed [63:0] clampl(input logic signed [63:0] v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return clampl(clampl(a) + clampl(b));
  endfunction

  function automatic logic signed [63:0] srnd(input logic signed [63:0] v,
                                              input logic [5:0] s);
    logic [63:0] m;
    m = mag(v);
    if (s == 6'd0) return v;
    m = (m + (64'd1 << (s - 6'd1))) >> s;
    return sat_mag(m, v[63]);
  endfunction

endpackage

/* hdl/lw_mdu.sv */
module lw_mdu import lw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  lw_req_t     req,
  output logic        done,
  output logic [63:0] res,
  output logic [63:0] rem
);

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_MFIN,
    U_DIV,
    U_DFIN
  } ustate_t;

  ustate_t      state;
  logic         sgn, rnd, neg, zero, sat;
  logic [5:0]   sh, cnt;
  logic [63:0]  ua, ub, q, rm, lo;
  logic [127:0] acc;

  logic [63:0]  ua_c, ub_c;
  logic [127:0] num;
  logic [63:0]  pp;
  logic [127:0] rnd_sum, shifted;
  logic [63:0]  mraw, rs, qf;
  logic         take;

  always_comb begin
    ua_c = req.sgn ? mag(req.a) : req.a;
    ub_c = req.sgn ? mag(req.b) : req.b;
    num  = {64'd0, ua_c} << req.sh;
    pp   = {32'd0, ua[(cnt[1] ? 32 : 0) +: 32]} * {32'd0, ub[(cnt[0] ? 32 : 0) +: 32]};
    rnd_sum = acc + (128'd1 << (sh - 6'd1));
    shifted = rnd_sum >> sh;
    mraw = (|shifted[127:64]) ? '1 : shifted[63:0];
    rs   = {rm[62:0], lo[63]};
    take = rm[63] || (rs >= ub);
    if (sat) begin
      qf = '1;
    end else if (rnd && (rm >= ub - rm) && (q != '1)) begin
      qf = q + 64'd1;
    end else begin
      qf = q;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= U_IDLE;
    end else begin
      case (state)
        U_IDLE: begin
          if (start) begin
            ua   <= ua_c;
            ub   <= ub_c;
            sgn  <= req.sgn;
            rnd  <= req.rnd;
            sh   <= req.sh;
            neg  <= req.sgn && (req.a[63] ^ req.b[63]);
            zero <= req.sgn && (req.a == 64'd0);
            sat  <= num[127:64] >= ub_c;
            acc  <= '0;
            cnt  <= '0;
            rm   <= num[127:64];
            lo   <= num[63:0];
            q    <= '0;
            if (req.op == OP_MUL) begin
              state <= U_MUL;
            end else if ((num[127:64] >= ub_c) || (req.sgn && (req.a == 64'd0))) begin
              state <= U_DFIN;
            end else begin
              state <= U_DIV;
            end
          end
        end
        U_MUL: begin
          acc <= acc + ({64'd0, pp} << ((cnt[1] ? 7'd32 : 7'd0) + (cnt[0] ? 7'd32 : 7'd0)));
          cnt <= cnt + 6'd1;
          if (cnt[1:0] == 2'd3) state <= U_MFIN;
        end
        U_MFIN: begin
          res   <= sgn ? sat_mag(mraw, neg) : mraw;
          done  <= 1'b1;
          state <= U_IDLE;
        end
        U_DIV: begin
          rm  <= take ? rs - ub : rs;
          lo  <= {lo[62:0], 1'b0};
          q   <= {q[62:0], take};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= U_DFIN;
        end
        U_DFIN: begin
          res   <= zero ? 64'd0 : (sgn ? sat_mag(qf, neg) : qf);
          rem   <= rm;
          done  <= 1'b1;
          state <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

/* hdl/lambert_w_evaluator.sv */
// principal-branch lambert w evaluator, signed fixed point
// input channel: in_valid / in_ready carry one word arg_z (48 bits, FRAC_BITS
// fraction bits); output channel: out_valid / out_ready carry w_value (37 bits)
// and not_converged
// one word at a time: in_ready is high only while the sequencer is idle
// all multiplication and division runs on one shared unit: a 32x32 multiplier
// that builds each 64x64 product from four partial products and a
// one-bit-per-cycle restoring divider
// an exponential sums up to 40 taylor terms; a logarithm normalizes with up to
// 62 shifts before its series; a word takes up to MAX_PASSES halley passes;
// an argument at or below -1/e finishes after one exponential
// the result waits in an output register; a new word is taken while it waits,
// and the sequencer holds its finished result until out_ready frees the register
// synchronous reset returns to idle and empties the output register
module lambert_w_evaluator import lw_pkg::*; #(
  parameter int MAX_PASSES = MAX_PASSES_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [47:0] arg_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [36:0] w_value,
  output logic               not_converged
);

  localparam int PW = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
  localparam logic signed [63:0] ONE    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] TWO    = 64'sd2 <<< FRAC_BITS;
  localparam logic signed [63:0] LIM_IN = 64'sd64 <<< FRAC_BITS;
  localparam logic signed [63:0] WLO    = (-ONE < OUT_MIN) ? OUT_MIN : -ONE;
  localparam logic [5:0] FSH  = 6'(FRAC_BITS);
  localparam logic [5:0] XSH  = 6'(56 - FRAC_BITS);

  typedef enum logic [5:0] {
    S_IDLE, S_EM1, S_CMP,
    S_T_Z2, S_T_Z3, S_T_Z4, S_T_Z5, S_T_D3, S_T_D24, S_T_SUM,
    S_L1, S_L2, S_L_A, S_L_D1, S_L_SQ, S_L_D2,
    S_P_EXP, S_P_WE, S_P_H1, S_P_H2, S_P_DEN, S_P_C, S_DONE,
    S_E_RED, S_E_DIV, S_E_MUL, S_E_TDIV, S_E_FIN,
    S_G_CHK, S_G_NORM, S_G_S, S_G_S2, S_G_MUL, S_G_TDIV, S_G_KL, S_G_FIN
  } state_t;

  state_t state, ret;
  logic   issued, flag;
  logic [PW-1:0] cnt;

  logic signed [63:0] z, w, arg, fres;
  logic signed [63:0] z2, z3, z4, z5, q3, q24;
  logic signed [63:0] l1, l2, va, d1, sq;
  logic signed [63:0] e, t, p, hv, h, den;
  logic signed [7:0]  k;
  logic [63:0] r60, sum, term, tmp, acc, s2, sv, m, kl;
  logic [7:0]  n;
  logic [5:0]  b;

  lw_req_t     req;
  logic        req_en, start, done;
  logic [63:0] res, rem;

  lw_mdu u_mdu (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .done  (done),
    .res   (res),
    .rem   (rem)
  );

  assign start    = req_en && !issued;
  assign in_ready = (state == S_IDLE);

  // exponential, range reduction and final scaling
  logic [63:0]        x56m, r56;
  logic signed [9:0]  esh, nsh;
  logic [63:0]        exp_val;
  // logarithm tail
  logic signed [7:0]  kk;
  logic [63:0]        kmag;
  logic signed [63:0] total;
  // taylor guess
  logic signed [63:0] v3, v8, v125, t3, t8, t125;
  // halley update
  logic signed [63:0] wn, wq;

  always_comb begin
    x56m = mag(arg) << XSH;
    if (x56m > LIM_U) x56m = LIM_U;
    if (!arg[63]) begin
      r56 = rem;
    end else if (rem != 64'd0) begin
      r56 = LN2_Q56 - rem;
    end else begin
      r56 = 64'd0;
    end
    esh = 10'sd60 - 10'sd0 - $signed(10'(FRAC_BITS)) - {{2{k[7]}}, k};
    nsh = -esh;
    if (esh >= 10'sd62) begin
      exp_val = 64'd0;
    end else if (esh > 10'sd0) begin
      exp_val = (sum + (64'd1 << (esh[5:0] - 6'd1))) >> esh[5:0];
    end else if ((nsh >= 10'sd62) || (sum > (LIM_U >> nsh[5:0]))) begin
      exp_val = LIM_U;
    end else begin
      exp_val = sum << nsh[5:0];
    end

    kk    = $signed({2'b00, b}) - $signed(8'(FRAC_BITS));
    kmag  = {56'd0, kk[7] ? 8'(-kk) : 8'(kk)};
    total = (kk[7] ? $signed(64'd0 - kl) : $signed(kl))
            + $signed(((acc << 1) + 64'd8) >> 4);

    v3   = z3 + (z3 <<< 1);
    v8   = z4 <<< 3;
    v125 = (z5 <<< 7) - (z5 <<< 1) - z5;
    t3   = sat_mag((mag(v3) + 64'd1) >> 1, v3[63]);
    t8   = sat_mag(q3, v8[63]);
    t125 = sat_mag(q24, v125[63]);

    wn = sadd(w, -$signed(res));
    wq = (wn < WLO) ? WLO : ((wn > OUT_MAX) ? OUT_MAX : wn);
  end

  // operand selection for the shared unit
  always_comb begin
    req_en  = 1'b0;
    req.op  = OP_MUL;
    req.sgn = 1'b0;
    req.rnd = 1'b0;
    req.sh  = 6'd0;
    req.a   = 64'd0;
    req.b   = 64'd0;
    case (state)
      S_E_DIV: begin
        req_en = 1'b1; req.op = OP_DIV; req.a = x56m; req.b = LN2_Q56;
      end
      S_E_MUL: begin
        req_en = 1'b1; req.sh = 6'd60; req.a = term; req.b = r60;
      end
      S_E_TDIV, S_G_TDIV: begin
        req_en = 1'b1; req.op = OP_DIV; req.a = (state == S_E_TDIV) ? tmp : term;
        req.b = {56'd0, n};
      end
      S_G_S: begin
        req_en = 1'b1; req.op = OP_DIV; req.rnd = 1'b1; req.sh = 6'd60;
        req.a = (m >> 2) - (64'd1 << 60); req.b = (m >> 2) + (64'd1 << 60);
      end
      S_G_S2: begin
        req_en = 1'b1; req.sh = 6'd60; req.a = sv; req.b = sv;
      end
      S_G_MUL: begin
        req_en = 1'b1; req.sh = 6'd60; req.a = term; req.b = s2;
      end
      S_G_KL: begin
        req_en = 1'b1; req.sh = 6'd1; req.a = kmag << 1; req.b = LN2_Q56;
      end
      S_T_Z2, S_T_Z3, S_T_Z4, S_T_Z5: begin
        req_en = 1'b1; req.sgn = 1'b1; req.sh = FSH; req.b = z;
        case (state)
          S_T_Z2:  req.a = z;
          S_T_Z3:  req.a = z2;
          S_T_Z4:  req.a = z3;
          default: req.a = z4;
        endcase
      end
      S_T_D3: begin
        req_en = 1'b1; req.op = OP_DIV; req.a = mag(v8) + 64'd1; req.b = 64'd3;
      end
      S_T_D24: begin
        req_en = 1'b1; req.op = OP_DIV; req.a = (mag(v125) + 64'd12) >> 3; req.b = 64'd3;
      end
      S_L_A: begin
        req_en = 1'b1; req.sgn = 1'b1; req.sh = FSH; req.a = l2; req.b = l2 - TWO;
      end
      S_L_D1: begin
        req_en = 1'b1; req.op = OP_DIV; req.sgn = 1'b1; req.rnd = 1'b1; req.sh = FSH;
        req.a = l2; req.b = l1;
      end
      S_L_SQ: begin
        req_en = 1'b1; req.sgn = 1'b1; req.sh = FSH; req.a = l1; req.b = l1;
      end
      S_L_D2: begin
        req_en = 1'b1; req.op = OP_DIV; req.sgn = 1'b1; req.rnd = 1'b1; req.sh = FSH;
        req.a = va; req.b = sq;
      end
      S_P_WE: begin
        req_en = 1'b1; req.sgn = 1'b1; req.sh = FSH; req.a = w; req.b = fres;
      end
      S_P_H1: begin
        req_en = 1'b1; req.sgn = 1'b1; req.sh = FSH; req.a = sadd(p, TWO); req.b = t;
      end
      S_P_H2: begin
        req_en = 1'b1; req.op = OP_DIV; req.sgn = 1'b1; req.rnd = 1'b1; req.sh = FSH;
        req.a = hv; req.b = p;
      end
      S_P_DEN: begin
        req_en = 1'b1; req.sgn = 1'b1; req.sh = FSH; req.a = e; req.b = p;
      end
      S_P_C: begin
        req_en = 1'b1; req.op = OP_DIV; req.sgn = 1'b1; req.rnd = 1'b1; req.sh = FSH;
        req.a = t; req.b = den;
      end
      default: req_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      flag      <= 1'b0;
      cnt       <= '0;
    end else begin
      if (req_en) begin
        if (!issued) issued <= 1'b1;
        else if (done) issued <= 1'b0;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            z     <= {{16{arg_z[47]}}, arg_z};
            flag  <= 1'b1;
            cnt   <= '0;
            state <= S_EM1;
          end
        end
        S_EM1: begin
          arg   <= -ONE;
          ret   <= S_CMP;
          state <= S_E_RED;
        end
        S_CMP: begin
          if (z <= -fres) begin
            w     <= -ONE;
            flag  <= 1'b0;
            state <= S_DONE;
          end else if (z < fres) begin
            state <= S_T_Z2;
          end else begin
            arg   <= z;
            ret   <= S_L1;
            state <= S_G_CHK;
          end
        end

        // fifth-order series guess
        S_T_Z2: if (issued && done) begin z2 <= $signed(res); state <= S_T_Z3; end
        S_T_Z3: if (issued && done) begin z3 <= $signed(res); state <= S_T_Z4; end
        S_T_Z4: if (issued && done) begin z4 <= $signed(res); state <= S_T_Z5; end
        S_T_Z5: if (issued && done) begin z5 <= $signed(res); state <= S_T_D3; end
        S_T_D3: if (issued && done) begin q3 <= $signed(res); state <= S_T_D24; end
        S_T_D24: if (issued && done) begin q24 <= $signed(res); state <= S_T_SUM; end
        S_T_SUM: begin
          w     <= z - z2 + t3 - t8 + t125;
          state <= S_P_EXP;
        end

        // logarithm-based guesses
        S_L1: begin
          l1 <= fres;
          if (fres < ONE) begin
            w     <= srnd(ONE + fres, 6'd1);
            state <= S_P_EXP;
          end else begin
            arg   <= fres;
            ret   <= S_L2;
            state <= S_G_CHK;
          end
        end
        S_L2: begin
          l2    <= fres;
          state <= S_L_A;
        end
        S_L_A: if (issued && done) begin va <= $signed(res); state <= S_L_D1; end
        S_L_D1: if (issued && done) begin d1 <= $signed(res); state <= S_L_SQ; end
        S_L_SQ: if (issued && done) begin sq <= $signed(res); state <= S_L_D2; end
        S_L_D2: begin
          if (issued && done) begin
            w     <= sadd(sadd(sadd(l1, -l2), d1), srnd($signed(res), 6'd1));
            state <= S_P_EXP;
          end
        end

        // halley pass
        S_P_EXP: begin
          arg   <= w;
          ret   <= S_P_WE;
          state <= S_E_RED;
        end
        S_P_WE: begin
          if (issued && done) begin
            e     <= fres;
            t     <= sadd($signed(res), -z);
            p     <= sadd(w, ONE);
            state <= S_P_H1;
          end
        end
        S_P_H1: if (issued && done) begin hv <= $signed(res); state <= S_P_H2; end
        S_P_H2: begin
          if (issued && done) begin
            h     <= srnd($signed(res), 6'd1);
            state <= S_P_DEN;
          end
        end
        S_P_DEN: begin
          if (issued && done) begin
            den   <= sadd($signed(res), -h);
            state <= S_P_C;
          end
        end
        S_P_C: begin
          if (issued && done) begin
            w <= wq;
            if (res == 64'd0) begin
              flag  <= 1'b0;
              state <= S_DONE;
            end else if (cnt == PW'(MAX_PASSES - 1)) begin
              state <= S_DONE;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= S_P_EXP;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            w_value       <= (w < OUT_MIN) ? OUT_MIN[36:0] :
                             ((w > OUT_MAX) ? OUT_MAX[36:0] : w[36:0]);
            not_converged <= flag;
            state         <= S_IDLE;
          end
        end

        // exponential subroutine: arg in, fres out
        S_E_RED: begin
          if (arg > LIM_IN) begin
            fres  <= LIM;
            state <= ret;
          end else if (arg < -LIM_IN) begin
            fres  <= 64'sd0;
            state <= ret;
          end else begin
            state <= S_E_DIV;
          end
        end
        S_E_DIV: begin
          if (issued && done) begin
            if (!arg[63]) k <= 8'(res);
            else if (rem != 64'd0) k <= -8'(res) - 8'sd1;
            else k <= -8'(res);
            r60   <= r56 << 4;
            sum   <= 64'd1 << 60;
            term  <= 64'd1 << 60;
            n     <= 8'd1;
            state <= S_E_MUL;
          end
        end
        S_E_MUL: if (issued && done) begin tmp <= res; state <= S_E_TDIV; end
        S_E_TDIV: begin
          if (issued && done) begin
            if (res == 64'd0) begin
              state <= S_E_FIN;
            end else begin
              sum  <= sum + res;
              term <= res;
              if (n == 8'd40) begin
                state <= S_E_FIN;
              end else begin
                n     <= n + 8'd1;
                state <= S_E_MUL;
              end
            end
          end
        end
        S_E_FIN: begin
          fres  <= $signed(exp_val);
          state <= ret;
        end

        // logarithm subroutine: arg in, fres out
        S_G_CHK: begin
          if (arg <= 64'sd0) begin
            fres  <= -LIM;
            state <= ret;
          end else begin
            m     <= arg;
            b     <= 6'd62;
            state <= S_G_NORM;
          end
        end
        S_G_NORM: begin
          // one bit of the leading-one search per cycle
          if ((b != 6'd0) && !m[62]) begin
            m <= m << 1;
            b <= b - 6'd1;
          end else begin
            state <= S_G_S;
          end
        end
        S_G_S: if (issued && done) begin sv <= res; state <= S_G_S2; end
        S_G_S2: begin
          if (issued && done) begin
            s2    <= res;
            acc   <= sv;
            term  <= sv;
            n     <= 8'd3;
            state <= S_G_MUL;
          end
        end
        S_G_MUL: begin
          if (issued && done) begin
            if (res == 64'd0) begin
              state <= S_G_KL;
            end else begin
              term  <= res;
              state <= S_G_TDIV;
            end
          end
        end
        S_G_TDIV: begin
          if (issued && done) begin
            acc <= acc + res;
            if (n == 8'd199) begin
              state <= S_G_KL;
            end else begin
              n     <= n + 8'd2;
              state <= S_G_MUL;
            end
          end
        end
        S_G_KL: if (issued && done) begin kl <= res; state <= S_G_FIN; end
        S_G_FIN: begin
          fres  <= srnd(total, XSH);
          state <= ret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
